>>> hdl/fir_decimator_65tap_core_assert.svh
// Assertion macros used by the checker file of the decimator.
`ifndef FIR_DECIMATOR_65TAP_CORE_ASSERT_SVH
`define FIR_DECIMATOR_65TAP_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define FDEC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define FDEC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define FDEC_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fdec_pkg.sv
`default_nettype none

package fdec_pkg;

    localparam int TAPS         = 65;
    localparam int SAMPLE_BITS  = 16;
    localparam int COEF_BITS    = 18;
    localparam int COEF_FRAC    = 20;
    localparam int ACC_BITS     = 40;
    localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
    localparam int RND_BITS     = ACC_BITS + 1;
    localparam int PTR_BITS     = 7;
    localparam int PHASE_BITS   = 6;
    localparam int FACTOR_BITS  = 7;
    localparam int FACTOR_MAX   = 64;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef logic [PTR_BITS-1:0]           ptr_t;
    typedef logic [PHASE_BITS-1:0]         phase_t;
    typedef logic [FACTOR_BITS-1:0]        factor_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic signed [RND_BITS-1:0]    rnd_t;

    // Register index decoded from paddr[2]
    typedef enum logic {
        REG_DECIM_FACTOR = 1'b0,
        REG_UNUSED       = 1'b1
    } reg_idx_t;

    localparam factor_t FACTOR_RESET = factor_t'(5);

    localparam rnd_t    ROUND_HALF = rnd_t'(1) << (COEF_FRAC - 1);
    localparam rnd_t    Y_MAX      = rnd_t'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam rnd_t    Y_MIN      = rnd_t'(-(2 ** (SAMPLE_BITS - 1)));
    localparam sample_t SAMPLE_MAX = sample_t'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam sample_t SAMPLE_MIN = sample_t'(-(2 ** (SAMPLE_BITS - 1)));

    // Kaiser low-pass weights, signed Q0.20, newest sample first
    localparam coef_t COEF_ROM [TAPS] = '{
        -18'sd87,   -18'sd116,  -18'sd129,  -18'sd113,  -18'sd52,
        18'sd70,    18'sd274,   18'sd580,   18'sd1011,  18'sd1589,
        18'sd2335,  18'sd3268,  18'sd4403,  18'sd5754,  18'sd7325,
        18'sd9117,  18'sd11124, 18'sd13332, 18'sd15719, 18'sd18256,
        18'sd20906, 18'sd23627, 18'sd26370, 18'sd29083, 18'sd31711,
        18'sd34197, 18'sd36487, 18'sd38526, 18'sd40268, 18'sd41669,
        18'sd42696, 18'sd43322, 18'sd43533, 18'sd43322, 18'sd42696,
        18'sd41669, 18'sd40268, 18'sd38526, 18'sd36487, 18'sd34197,
        18'sd31711, 18'sd29083, 18'sd26370, 18'sd23627, 18'sd20906,
        18'sd18256, 18'sd15719, 18'sd13332, 18'sd11124, 18'sd9117,
        18'sd7325,  18'sd5754,  18'sd4403,  18'sd3268,  18'sd2335,
        18'sd1589,  18'sd1011,  18'sd580,   18'sd274,   18'sd70,
        -18'sd52,   -18'sd113,  -18'sd129,  -18'sd116,  -18'sd87
    };

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        ptr_t rd_tap;
        logic rd_last;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic acc_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/fdec_ram.sv
`default_nettype none

module fdec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/fdec_ctrl.sv
`default_nettype none

module fdec_ctrl
    import fdec_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MAC   = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;
    ptr_t   tap_reg, tap_next;
    logic   accept;
    logic   last_tap;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign last_tap = (tap_reg == ptr_t'(TAPS - 1));

    always_comb begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        cmd.wr_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_tap   = tap_reg;
        cmd.rd_last  = last_tap;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.wr_en = accept;
                tap_next  = '0;
                if (accept && status.emit) begin
                    state_next = S_MAC;
                end
            end
            S_MAC: begin
                cmd.rd_en = 1'b1;
                tap_next  = last_tap ? '0 : tap_reg + ptr_t'(1);
                if (last_tap) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // hold until the sum is complete and the output register is free
                if (status.acc_done && status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fdec_datapath.sv
`default_nettype none

module fdec_datapath
    import fdec_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cmd_t    cmd,
    output status_t      status,
    input  wire factor_t decim_factor,
    input  wire sample_t sample_in,
    output sample_t      filtered_out,
    output logic         out_valid,
    input  wire logic    out_ready
);

    ptr_t             wp_reg;
    ptr_t             rp_reg;
    phase_t           phase_reg;
    logic [TAPS-1:0]  written_reg;
    logic             rd_v_reg, last1_reg, hit_reg;
    coef_t            coef_reg;
    logic             prod_v_reg, last2_reg;
    prod_t            prod_reg;
    acc_t             acc_reg;
    logic             acc_done_reg;
    logic             out_valid_reg;
    sample_t          out_reg;

    factor_t          eff_factor;
    factor_t          phase_inc;
    logic [SAMPLE_BITS-1:0] ram_q;
    sample_t          tap_sample;
    rnd_t             rnd;
    rnd_t             quo;
    sample_t          y_sat;

    always_comb begin
        if (decim_factor == '0) begin
            eff_factor = factor_t'(1);
        end else if (decim_factor > factor_t'(FACTOR_MAX)) begin
            eff_factor = factor_t'(FACTOR_MAX);
        end else begin
            eff_factor = decim_factor;
        end
    end

    assign phase_inc       = {1'b0, phase_reg} + factor_t'(1);
    assign status.emit     = (phase_inc >= eff_factor);
    assign status.acc_done = acc_done_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    fdec_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_hist (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (wp_reg),
        .wdata (sample_in),
        .raddr (rp_reg),
        .rdata (ram_q)
    );

    // never-written slots read as zero
    assign tap_sample = hit_reg ? sample_t'(ram_q) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            phase_reg     <= '0;
            written_reg   <= '0;
            rd_v_reg      <= 1'b0;
            last1_reg     <= 1'b0;
            prod_v_reg    <= 1'b0;
            last2_reg     <= 1'b0;
            acc_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                written_reg[wp_reg] <= 1'b1;
                wp_reg    <= (wp_reg == ptr_t'(TAPS - 1)) ? '0 : wp_reg + ptr_t'(1);
                phase_reg <= status.emit ? '0 : phase_inc[PHASE_BITS-1:0];
            end
            rd_v_reg   <= cmd.rd_en;
            last1_reg  <= cmd.rd_en && cmd.rd_last;
            prod_v_reg <= rd_v_reg;
            last2_reg  <= last1_reg;
            if (cmd.wr_en) begin
                acc_done_reg <= 1'b0;
            end else if (last2_reg) begin
                acc_done_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            rp_reg <= wp_reg;
        end else if (cmd.rd_en) begin
            rp_reg <= (rp_reg == '0) ? ptr_t'(TAPS - 1) : rp_reg - ptr_t'(1);
        end
        hit_reg  <= written_reg[rp_reg];
        coef_reg <= COEF_ROM[cmd.rd_tap];
        prod_reg <= tap_sample * coef_reg;
        if (cmd.wr_en) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            acc_reg <= acc_reg + acc_t'(prod_reg);
        end
        if (cmd.load_out) begin
            out_reg <= y_sat;
        end
    end

    // round half up, then saturate
    always_comb begin
        rnd = rnd_t'(acc_reg) + ROUND_HALF;
        quo = rnd >>> COEF_FRAC;
        if (quo > Y_MAX) begin
            y_sat = SAMPLE_MAX;
        end else if (quo < Y_MIN) begin
            y_sat = SAMPLE_MIN;
        end else begin
            y_sat = quo[SAMPLE_BITS-1:0];
        end
    end

    assign filtered_out = out_reg;
    assign out_valid    = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/fir_decimator_65tap_core.sv
// Flow: a sample that completes a decimation period has its result formed by 65 history reads
//   on one MAC through read, multiply and accumulate stages, then loaded once output is free.
// Throughput: 1 sample per cycle that gives no result; a sample that does keeps s_tready low
//   until its result is loaded; the single shared multiply-accumulate over 65 taps sets this.
// Reset: aresetn synchronous, active low; clears history valid bits, write and tap pointers,
//   phase and output valid, and sets decim_factor to 5. No clearing pass is needed.
`default_nettype none

module fir_decimator_65tap_core
    import fdec_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [15:0]              s_tdata,   // [15:0] sample_in
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [15:0]                   m_tdata,   // [15:0] filtered_out
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    factor_t  factor_reg;
    reg_idx_t reg_idx;
    cmd_t     cmd;
    status_t  status;
    sample_t  filtered_out;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_RESET;
        end else if (psel && penable && pwrite && pready
                     && reg_idx == REG_DECIM_FACTOR) begin
            factor_reg <= pwdata[FACTOR_BITS-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DECIM_FACTOR: prdata = APB_DATA_BITS'(factor_reg);
            default:          prdata = '0;
        endcase
    end

    fdec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fdec_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .decim_factor (factor_reg),
        .sample_in    (sample_t'(s_tdata)),
        .filtered_out (filtered_out),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

    assign m_tdata = filtered_out;

endmodule

`default_nettype wire

>>> hdl/fdec_checker.sv
`default_nettype none

`include "fir_decimator_65tap_core_assert.svh"

module fdec_checker
    import fdec_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tready,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [15:0]              m_tdata,
    input wire logic                     psel,
    input wire logic                     penable,
    input wire logic                     pwrite,
    input wire logic [APB_ADDR_BITS-1:0] paddr,
    input wire logic [APB_DATA_BITS-1:0] pwdata,
    input wire logic [APB_DATA_BITS-1:0] prdata,
    input wire logic                     pready
);

    `FDEC_ASSERT_RST(a_rst_out_idle, aclk, !aresetn, !m_tvalid, "result valid after reset")

    `FDEC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    `FDEC_ASSERT_IMP(a_out_after_busy, aclk, aresetn, $rose(m_tvalid), !$past(s_tready), "result appeared while input side was open")

    `FDEC_ASSERT_NXT(a_factor_readback, aclk, aresetn, psel && penable && pwrite && pready && paddr == '0, prdata[FACTOR_BITS-1:0] == $past(pwdata[FACTOR_BITS-1:0]), "decim_factor readback mismatch")

endmodule

bind fir_decimator_65tap_core fdec_checker u_fdec_checker (.*);

`default_nettype wire
